// ----- rtl/core/bsa_pkg.sv -----
// Package for the bitmap slot allocator: sizes, operation and status codes,
// and the control and result structs of the row scan unit. No dependencies.
`default_nettype none

package bsa_pkg;

  localparam int SLOTS     = 128;
  localparam int SLOT_W    = 7;
  localparam int RES_W     = 8;
  localparam int ROW_W     = 8;
  localparam int ROWS      = SLOTS / ROW_W;
  localparam int ROW_IDX_W = $clog2(ROWS);
  localparam int BIT_IDX_W = $clog2(ROW_W);
  localparam int STEP_W    = $clog2(ROWS + 1) + 1;

  typedef enum logic [2:0] {
    KIND_ALLOC   = 3'd0,
    KIND_RELEASE = 3'd1,
    KIND_FIRST   = 3'd2,
    KIND_NEXT    = 3'd3,
    KIND_PREV    = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_WASFREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MASK_ALL = 2'd0,
    MASK_GE  = 2'd1,
    MASK_LT  = 2'd2
  } mask_t;

  typedef struct packed {
    logic                 invert;
    logic                 down;
    mask_t                mask;
    logic [BIT_IDX_W-1:0] bit_idx;
  } scan_ctl_t;

  typedef struct packed {
    logic                 hit;
    logic [BIT_IDX_W-1:0] pos;
  } scan_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/bsa_if.sv -----
// Channel interfaces of the bitmap slot allocator: request and result.
// Depends on bsa_pkg for field widths.
`default_nettype none

interface bsa_in_if;
  logic                        valid;
  logic                        ready;
  logic [2:0]                  kind;
  logic [bsa_pkg::SLOT_W-1:0]  slot;

  modport source (output valid, output kind, output slot, input ready);
  modport sink   (input valid, input kind, input slot, output ready);
endinterface

interface bsa_out_if;
  logic                        valid;
  logic                        ready;
  logic [bsa_pkg::RES_W-1:0]   result_slot;
  logic [1:0]                  status;
  logic [bsa_pkg::RES_W-1:0]   used_count;

  modport source (output valid, output result_slot, output status, output used_count,
                  input ready);
  modport sink   (input valid, input result_slot, input status, input used_count,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/bsa_row_scan.sv -----
// Shared scan unit: masks one bitmap row, optionally inverted, and finds its lowest or highest set bit.
// Depends on bsa_pkg (scan_ctl_t, scan_res_t).
`default_nettype none

module bsa_row_scan (
  input  wire logic [bsa_pkg::ROW_W-1:0] row,
  input  wire bsa_pkg::scan_ctl_t        ctl,
  output bsa_pkg::scan_res_t             res
);

  always_comb begin
    logic [bsa_pkg::ROW_W-1:0] eff;
    logic [bsa_pkg::ROW_W-1:0] msk;
    eff = ctl.invert ? ~row : row;
    for (int i = 0; i < bsa_pkg::ROW_W; i++) begin
      case (ctl.mask)
        bsa_pkg::MASK_GE: msk[i] = (bsa_pkg::BIT_IDX_W'(i) >= ctl.bit_idx);
        bsa_pkg::MASK_LT: msk[i] = (bsa_pkg::BIT_IDX_W'(i) < ctl.bit_idx);
        default:          msk[i] = 1'b1;
      endcase
    end
    eff = eff & msk;
    res.hit = |eff;
    res.pos = '0;
    if (ctl.down) begin
      for (int i = 0; i < bsa_pkg::ROW_W; i++) begin
        if (eff[i]) res.pos = bsa_pkg::BIT_IDX_W'(i);
      end
    end else begin
      for (int i = bsa_pkg::ROW_W - 1; i >= 0; i--) begin
        if (eff[i]) res.pos = bsa_pkg::BIT_IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bitmap_slot_allocator.sv -----
// Top level of the bitmap slot allocator: sequencer, occupancy rows, used count.
// Depends on bsa_pkg, bsa_in_if, bsa_out_if and bsa_row_scan.
//
//  channel  | dir | transfer fields
//  ---------+-----+-----------------------------------------
//  in_ch    | in  | kind[2:0], slot[6:0]
//  out_ch   | out | result_slot[7:0], status[1:0], used_count[7:0]
//
// One request at a time. Release and unused kinds skip the scan and finish
// from S_ONE. Allocate and first scan up to 16 rows, next and previous
// up to 17, one row of eight slots per cycle through the shared row scan unit.
// Reset clears all occupancy rows and the count together; no sweep.
// The result sits in an output register; a new request is taken while it waits,
// and the sequencer holds its final step until that register is free.
`default_nettype none

module bitmap_slot_allocator (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bsa_in_if.sink      in_ch,
  bsa_out_if.source   out_ch
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ONE
  } state_t;

  localparam logic [bsa_pkg::STEP_W-1:0] STEP_LAST_LIN  = bsa_pkg::STEP_W'(bsa_pkg::ROWS - 1);
  localparam logic [bsa_pkg::STEP_W-1:0] STEP_LAST_WRAP = bsa_pkg::STEP_W'(bsa_pkg::ROWS);
  localparam logic [bsa_pkg::RES_W-1:0]  NONE_SLOT      = bsa_pkg::RES_W'(bsa_pkg::SLOTS);
  localparam logic [bsa_pkg::RES_W-1:0]  COUNT_MAX      = bsa_pkg::RES_W'(bsa_pkg::SLOTS);

  state_t                          state_r, state_nxt;
  logic [2:0]                      op_r, op_nxt;
  logic [bsa_pkg::SLOT_W-1:0]      base_r, base_nxt;
  logic [bsa_pkg::ROW_IDX_W-1:0]   row_r, row_nxt;
  logic [bsa_pkg::STEP_W-1:0]      step_r, step_nxt;
  logic [bsa_pkg::RES_W-1:0]       count_r, count_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [bsa_pkg::RES_W-1:0]       out_slot_r, out_slot_nxt;
  logic [1:0]                      out_status_r, out_status_nxt;
  logic [bsa_pkg::RES_W-1:0]       out_used_r, out_used_nxt;

  logic [bsa_pkg::ROW_W-1:0]       map_r [bsa_pkg::ROWS];
  logic                            map_we;
  logic [bsa_pkg::ROW_W-1:0]       map_wdata;
  logic [bsa_pkg::ROW_W-1:0]       row_data;

  bsa_pkg::scan_ctl_t              scan_ctl;
  bsa_pkg::scan_res_t              scan_res;

  logic                            out_free;
  logic                            last_step;
  logic                            is_wrap_op;
  logic [bsa_pkg::SLOT_W:0]        slot_inc;
  logic [bsa_pkg::SLOT_W-1:0]      next_start;
  logic [bsa_pkg::RES_W-1:0]       found_slot;

  assign row_data = map_r[row_r];

  bsa_row_scan u_scan (
    .row (row_data),
    .ctl (scan_ctl),
    .res (scan_res)
  );

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_slot = out_slot_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.used_count  = out_used_r;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign is_wrap_op = (op_r == bsa_pkg::KIND_NEXT) || (op_r == bsa_pkg::KIND_PREV);
  assign last_step  = is_wrap_op ? (step_r == STEP_LAST_WRAP) : (step_r == STEP_LAST_LIN);
  assign slot_inc   = {1'b0, in_ch.slot} + (bsa_pkg::SLOT_W + 1)'(1);
  assign next_start = slot_inc[bsa_pkg::SLOT_W] ? '0 : slot_inc[bsa_pkg::SLOT_W-1:0];
  assign found_slot = {1'b0, row_r, scan_res.pos};

  always_comb begin
    scan_ctl.invert  = (op_r == bsa_pkg::KIND_ALLOC);
    scan_ctl.down    = (op_r == bsa_pkg::KIND_PREV);
    scan_ctl.bit_idx = base_r[bsa_pkg::BIT_IDX_W-1:0];
    scan_ctl.mask    = bsa_pkg::MASK_ALL;
    if (op_r == bsa_pkg::KIND_NEXT) begin
      if (step_r == '0)                scan_ctl.mask = bsa_pkg::MASK_GE;
      else if (step_r == STEP_LAST_WRAP) scan_ctl.mask = bsa_pkg::MASK_LT;
    end else if (op_r == bsa_pkg::KIND_PREV) begin
      if (step_r == '0)                scan_ctl.mask = bsa_pkg::MASK_LT;
      else if (step_r == STEP_LAST_WRAP) scan_ctl.mask = bsa_pkg::MASK_GE;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    base_nxt       = base_r;
    row_nxt        = row_r;
    step_nxt       = step_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_slot_nxt   = out_slot_r;
    out_status_nxt = out_status_r;
    out_used_nxt   = out_used_r;
    map_we         = 1'b0;
    map_wdata      = row_data;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          op_nxt   = in_ch.kind;
          step_nxt = '0;
          case (in_ch.kind)
            bsa_pkg::KIND_ALLOC, bsa_pkg::KIND_FIRST: begin
              base_nxt  = '0;
              row_nxt   = '0;
              state_nxt = S_SCAN;
            end
            bsa_pkg::KIND_NEXT: begin
              base_nxt  = next_start;
              row_nxt   = next_start[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_IDX_W];
              state_nxt = S_SCAN;
            end
            bsa_pkg::KIND_PREV: begin
              base_nxt  = in_ch.slot;
              row_nxt   = in_ch.slot[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_IDX_W];
              state_nxt = S_SCAN;
            end
            default: begin
              base_nxt  = in_ch.slot;
              row_nxt   = in_ch.slot[bsa_pkg::SLOT_W-1:bsa_pkg::BIT_IDX_W];
              state_nxt = S_ONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (scan_res.hit || last_step) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = bsa_pkg::ST_OK;
            out_slot_nxt   = found_slot;
            case (op_r)
              bsa_pkg::KIND_ALLOC: begin
                if (scan_res.hit) begin
                  map_we    = 1'b1;
                  map_wdata = row_data | (bsa_pkg::ROW_W'(1) << scan_res.pos);
                  count_nxt = count_r + bsa_pkg::RES_W'(1);
                end else begin
                  out_slot_nxt   = '0;
                  out_status_nxt = bsa_pkg::ST_FULL;
                end
              end
              bsa_pkg::KIND_PREV: begin
                if (!scan_res.hit) begin
                  out_slot_nxt   = NONE_SLOT;
                  out_status_nxt = bsa_pkg::ST_EMPTY;
                end
              end
              default: begin
                if (!scan_res.hit) begin
                  out_slot_nxt   = '0;
                  out_status_nxt = bsa_pkg::ST_EMPTY;
                end
              end
            endcase
            out_used_nxt = count_nxt;
            state_nxt    = S_IDLE;
          end
        end else begin
          step_nxt = step_r + bsa_pkg::STEP_W'(1);
          row_nxt  = scan_ctl.down ? row_r - bsa_pkg::ROW_IDX_W'(1)
                                   : row_r + bsa_pkg::ROW_IDX_W'(1);
        end
      end

      S_ONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_slot_nxt   = '0;
          out_status_nxt = bsa_pkg::ST_OK;
          if (op_r == bsa_pkg::KIND_RELEASE) begin
            out_slot_nxt = {1'b0, base_r};
            if (row_data[base_r[bsa_pkg::BIT_IDX_W-1:0]]) begin
              map_we    = 1'b1;
              map_wdata = row_data &
                          ~(bsa_pkg::ROW_W'(1) << base_r[bsa_pkg::BIT_IDX_W-1:0]);
              if (count_r != '0) count_nxt = count_r - bsa_pkg::RES_W'(1);
            end else begin
              out_status_nxt = bsa_pkg::ST_WASFREE;
            end
          end
          out_used_nxt = count_nxt;
          state_nxt    = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
    op_r         <= op_nxt;
    base_r       <= base_nxt;
    row_r        <= row_nxt;
    out_slot_r   <= out_slot_nxt;
    out_status_r <= out_status_nxt;
    out_used_r   <= out_used_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bsa_pkg::ROWS; i++) map_r[i] <= '0;
    end else if (map_we) begin
      map_r[row_r] <= map_wdata;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_MAX)
    else $error("used count above slot total");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> step_r <= STEP_LAST_WRAP)
    else $error("scan ran past its last row");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == bsa_pkg::ST_FULL |-> out_used_r == COUNT_MAX)
    else $error("full reported with free slots");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r == bsa_pkg::ST_EMPTY |-> out_used_r == '0)
    else $error("no used slot reported with nonzero count");

  a_release_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ONE |=> count_r <= $past(count_r))
    else $error("release raised the count");

endmodule

`default_nettype wire

// ----- sim/bitmap_slot_allocator_test.sv -----
// Self-checking testbench for bitmap_slot_allocator: drives requests, predicts
// every reply from its own bitmap and count, and compares each transfer.
// Depends on bsa_pkg, bsa_in_if, bsa_out_if and the RTL of the allocator.
`timescale 1ns / 1ps

module bitmap_slot_allocator_test;

  localparam int          STALL_LIMIT      = 3000;
  localparam int          HOLD_CYCLES      = 300;
  localparam int          DRAIN_CYCLES     = 40;
  localparam int          MAX_PRINTS       = 40;
  localparam logic [2:0]  KIND_SPARE_FIRST = 3'd5;
  localparam logic [6:0]  TOP_SLOT         = 7'(bsa_pkg::SLOTS - 1);

  typedef struct packed {
    logic [bsa_pkg::RES_W-1:0] slot_no;
    bsa_pkg::status_t          status;
    logic [bsa_pkg::RES_W-1:0] used;
  } reply_t;

  logic clk = 1'b0;
  logic rst_n;

  bsa_in_if  in_ch ();
  bsa_out_if out_ch ();

  bitmap_slot_allocator dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [bsa_pkg::SLOTS-1:0] slot_map;
  logic [bsa_pkg::RES_W-1:0] used_slots;
  reply_t                    pending_replies[$];

  int idle_pct     = 6;
  bit hold_request = 1'b0;
  int requests_sent;
  int replies_checked;
  int mismatches;
  int full_seen;
  int empty_seen;
  int twice_freed_seen;
  int quiet_cycles;

  always #5 clk = ~clk;

  // what the allocator should answer, applied to the tracked state
  function automatic void predict_reply(logic [2:0] op, logic [6:0] idx);
    reply_t r;
    int     start;
    int     p;
    int     found;
    int     top;
    int     below;
    r.slot_no = '0;
    r.status  = bsa_pkg::ST_OK;
    case (op)
      bsa_pkg::KIND_ALLOC: begin
        r.status = bsa_pkg::ST_FULL;
        for (p = 0; p < bsa_pkg::SLOTS; p++) begin
          if (!slot_map[p] && r.status == bsa_pkg::ST_FULL) begin
            slot_map[p] = 1'b1;
            used_slots  = used_slots + 1'b1;
            r.slot_no   = bsa_pkg::RES_W'(p);
            r.status    = bsa_pkg::ST_OK;
          end
        end
      end
      bsa_pkg::KIND_RELEASE: begin
        r.slot_no = bsa_pkg::RES_W'(idx);
        if (slot_map[idx]) begin
          slot_map[idx] = 1'b0;
          if (used_slots != 0) used_slots = used_slots - 1'b1;
        end else begin
          r.status = bsa_pkg::ST_WASFREE;
        end
      end
      bsa_pkg::KIND_FIRST, bsa_pkg::KIND_NEXT: begin
        start = (op == bsa_pkg::KIND_FIRST) ? 0 : int'(idx) + 1;
        if (start >= bsa_pkg::SLOTS) start = 0;
        found = bsa_pkg::SLOTS;
        for (p = 0; p < bsa_pkg::SLOTS; p++) begin
          if (found == bsa_pkg::SLOTS && slot_map[(start + p) % bsa_pkg::SLOTS])
            found = (start + p) % bsa_pkg::SLOTS;
        end
        if (found == bsa_pkg::SLOTS) r.status = bsa_pkg::ST_EMPTY;
        else r.slot_no = bsa_pkg::RES_W'(found);
      end
      bsa_pkg::KIND_PREV: begin
        top   = bsa_pkg::SLOTS;
        below = bsa_pkg::SLOTS;
        for (p = bsa_pkg::SLOTS - 1; p >= 0; p--) begin
          if (slot_map[p]) begin
            if (top == bsa_pkg::SLOTS) top = p;
            if (p < int'(idx) && below == bsa_pkg::SLOTS) below = p;
          end
        end
        if (below != bsa_pkg::SLOTS) begin
          r.slot_no = bsa_pkg::RES_W'(below);
        end else if (top != bsa_pkg::SLOTS) begin
          r.slot_no = bsa_pkg::RES_W'(top);
        end else begin
          r.slot_no = bsa_pkg::RES_W'(bsa_pkg::SLOTS);
          r.status  = bsa_pkg::ST_EMPTY;
        end
      end
      default: ;
    endcase
    r.used = used_slots;
    pending_replies.push_back(r);
  endfunction

  // entered and left at a falling edge
  task automatic send_request(logic [2:0] op, logic [6:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= op;
    in_ch.slot  <= idx;
    do @(posedge clk); while (!in_ch.ready);
    predict_reply(op, idx);
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("%0t mismatch: %s", $realtime, msg);
  endtask

  function automatic logic [6:0] pick_used_slot();
    int         base;
    logic [6:0] pick;
    base = $urandom_range(bsa_pkg::SLOTS - 1);
    pick = 7'(base);
    if (used_slots != 0 && $urandom_range(99) < 85) begin
      for (int i = bsa_pkg::SLOTS - 1; i >= 0; i--) begin
        if (slot_map[(base + i) % bsa_pkg::SLOTS]) pick = 7'((base + i) % bsa_pkg::SLOTS);
      end
    end
    return pick;
  endfunction

  function automatic logic [6:0] pick_probe_slot();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 20) return TOP_SLOT;
    if (r < 35) return pick_used_slot();
    return 7'($urandom_range(bsa_pkg::SLOTS - 1));
  endfunction

  task automatic send_query();
    int r;
    r = $urandom_range(99);
    if (r < 8) send_request(KIND_SPARE_FIRST + 3'($urandom_range(2)), 7'($urandom));
    else if (r < 30) send_request(bsa_pkg::KIND_FIRST, 7'($urandom));
    else if (r < 65) send_request(bsa_pkg::KIND_NEXT, pick_probe_slot());
    else send_request(bsa_pkg::KIND_PREV, pick_probe_slot());
  endtask

  task automatic run_churn(int items, int alloc_pct, int release_pct);
    int r;
    repeat (items) begin
      r = $urandom_range(99);
      if (r < alloc_pct) send_request(bsa_pkg::KIND_ALLOC, 7'($urandom));
      else if (r < alloc_pct + release_pct)
        send_request(bsa_pkg::KIND_RELEASE, pick_used_slot());
      else send_query();
    end
  endtask

  task automatic test_empty_and_basic();
    send_request(bsa_pkg::KIND_FIRST, '0);
    send_request(bsa_pkg::KIND_NEXT, TOP_SLOT);
    send_request(bsa_pkg::KIND_PREV, '0);
    send_request(bsa_pkg::KIND_RELEASE, '0);
    send_request(bsa_pkg::KIND_RELEASE, TOP_SLOT);
    send_request(KIND_SPARE_FIRST, 7'h55);
    send_request(KIND_SPARE_FIRST + 3'd1, 7'h2a);
    send_request(KIND_SPARE_FIRST + 3'd2, TOP_SLOT);
    repeat (3) send_request(bsa_pkg::KIND_ALLOC, '0);
    send_request(bsa_pkg::KIND_RELEASE, 7'd1);
    send_request(bsa_pkg::KIND_NEXT, '0);
    send_request(bsa_pkg::KIND_NEXT, 7'd2);
    send_request(bsa_pkg::KIND_NEXT, TOP_SLOT);
    send_request(bsa_pkg::KIND_PREV, 7'd2);
    send_request(bsa_pkg::KIND_PREV, '0);
    send_request(bsa_pkg::KIND_FIRST, '0);
    send_request(bsa_pkg::KIND_RELEASE, 7'd1);
    send_request(bsa_pkg::KIND_ALLOC, '0);
    send_request(bsa_pkg::KIND_RELEASE, '0);
    send_request(bsa_pkg::KIND_RELEASE, 7'd2);
    send_request(bsa_pkg::KIND_RELEASE, 7'd1);
    send_request(bsa_pkg::KIND_PREV, 7'd64);
  endtask

  task automatic test_fill_to_full();
    while (used_slots < bsa_pkg::SLOTS) begin
      if ($urandom_range(99) < 20) send_query();
      else send_request(bsa_pkg::KIND_ALLOC, 7'($urandom));
    end
    repeat (3) send_request(bsa_pkg::KIND_ALLOC, 7'($urandom));
    send_request(bsa_pkg::KIND_NEXT, TOP_SLOT);
    send_request(bsa_pkg::KIND_PREV, '0);
    send_request(bsa_pkg::KIND_RELEASE, TOP_SLOT);
    send_request(bsa_pkg::KIND_RELEASE, '0);
    send_request(bsa_pkg::KIND_NEXT, TOP_SLOT);
    send_request(bsa_pkg::KIND_PREV, 7'd1);
    send_request(bsa_pkg::KIND_NEXT, TOP_SLOT - 7'd1);
    send_request(bsa_pkg::KIND_ALLOC, '0);
    send_request(bsa_pkg::KIND_ALLOC, '0);
    send_request(bsa_pkg::KIND_ALLOC, '0);
  endtask

  task automatic test_random_churn();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase % 2 == 0) run_churn(150, 10, 70);
      else run_churn(150, 70, 10);
    end
  endtask

  task automatic test_no_gaps();
    idle_pct = 0;
    run_churn(150, 40, 40);
    idle_pct = 6;
  endtask

  task automatic test_output_hold();
    hold_request = 1'b1;
    run_churn(40, 40, 40);
  endtask

  initial begin
    int held;
    bit hold_served;
    held        = 0;
    hold_served = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_served) begin
        out_ch.ready <= 1'b0;
        held++;
        if (held == HOLD_CYCLES) hold_served = 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply with none pending: slot %0d status %0d used %0d",
                                  out_ch.result_slot, out_ch.status, out_ch.used_count));
      end else begin
        want = pending_replies.pop_front();
        replies_checked++;
        if (want.status == bsa_pkg::ST_FULL) full_seen++;
        if (want.status == bsa_pkg::ST_EMPTY) empty_seen++;
        if (want.status == bsa_pkg::ST_WASFREE) twice_freed_seen++;
        if (out_ch.result_slot !== want.slot_no)
          report_mismatch($sformatf("result_slot %0d, want %0d", out_ch.result_slot,
                                    want.slot_no));
        if (out_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_ch.status, want.status));
        if (out_ch.used_count !== want.used)
          report_mismatch($sformatf("used_count %0d, want %0d", out_ch.used_count,
                                    want.used));
      end
    end
  end

  // stall watchdog: no transfer on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind  = '0;
    in_ch.slot  = '0;
    slot_map    = '0;
    used_slots  = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_and_basic();
    test_fill_to_full();
    test_random_churn();
    test_no_gaps();
    test_output_hold();

    in_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d checked replies, allocation from empty to full",
             requests_sent, replies_checked);
    $display("  full %0d, empty %0d, release of free slot %0d, mismatches %0d",
             full_seen, empty_seen, twice_freed_seen, mismatches);
    if (mismatches == 0 && pending_replies.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
